### hw/rtl/efbrp_pkg.sv
// ----------------------------------------------------------------------------
// efbrp_pkg: shared types and constants of the fuse block remap planner
// Result codes, command and status bundles, controller states, tag function.
// ----------------------------------------------------------------------------
`default_nettype none

package efbrp_pkg;

	localparam int MAP_SLOTS      = 29;
	localparam int PHYS_BLOCKS    = 32;
	localparam int LOGICAL_BLOCKS = 16;

	localparam int IDX_W   = 5;
	localparam int SLOT_W  = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
	localparam int WORD_W  = 64;
	localparam int BLOCK_W = 2 * WORD_W;

	localparam logic FN_LOAD = 1'b0;
	localparam logic FN_PLAN = 1'b1;

	typedef enum logic [2:0] {
		ST_REUSE   = 3'd0,
		ST_NEW     = 3'd1,
		ST_SKIP    = 3'd2,
		ST_FULL    = 3'd3,
		ST_INVALID = 3'd4,
		ST_LOADED  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_HIT,
		S_RD_HIT,
		S_CHK_HIT,
		S_SCAN_FREE,
		S_RD_FREE,
		S_CHK_FREE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    load_wr;
		logic    scan_fwd_init;
		logic    scan_rev_init;
		logic    scan_fwd_step;
		logic    scan_rev_step;
		logic    slot_take;
		logic    rd;
		logic    commit;
		logic    res_load;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		logic plan;
		logic idx_big;
		logic hit;
		logic free;
		logic cnt_last;
		logic cnt_zero;
		logic all_ff;
		logic rises;
		logic out_busy;
	} sts_t;

	// Bits 5..0 index, bit 6 inverted parity of bits 0..3, bit 7 of bits 2..5.
	function automatic logic [7:0] make_tag(input logic [IDX_W-1:0] idx);
		logic [5:0] a;
		a = 6'(idx);
		return {~^a[5:2], ~^a[3:0], a};
	endfunction

endpackage

`default_nettype wire

### hw/rtl/efbrp_req_if.sv
// ----------------------------------------------------------------------------
// efbrp_req_if: request channel of the planner
// Carries one load or plan transaction with its 16 data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface efbrp_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [4:0]  block_index;
	logic [63:0] data_low;
	logic [63:0] data_high;

	modport source (output valid, func, block_index, data_low, data_high, input ready);
	modport sink   (input valid, func, block_index, data_low, data_high, output ready);
endinterface

`default_nettype wire

### hw/rtl/efbrp_rsp_if.sv
// ----------------------------------------------------------------------------
// efbrp_rsp_if: response channel of the planner
// Carries the status, chosen slot and map tag of one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface efbrp_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [4:0] slot;
	logic [7:0] tag;

	modport source (output valid, status, slot, tag, input ready);
	modport sink   (input valid, status, slot, tag, output ready);
endinterface

`default_nettype wire

### hw/rtl/efuse_block_remap_planner_core.sv
// ----------------------------------------------------------------------------
// efuse_block_remap_planner_core: fuse block remap planner
// Loads current block contents and the usage map, then plans per logical
// block which slot takes the new bytes and which map tag goes with it.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  req     | in  | valid / ready | func, block_index, data_low, data_high
//  rsp     | out | valid / ready | status, slot, tag
//
//  Scans: a load needs no scan of the map. A plan makes up to two serial
//  walks over the 29 map slots (forward for the tag match, backward for the
//  free slot).
//  Reset: arst_n clears the sequencer, the usage map and the response valid.
//  Stalls: the next transaction is accepted once the previous result sits in
//  the response register; a result waits in the sequencer while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module efuse_block_remap_planner_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	efbrp_req_if.sink     req,
	efbrp_rsp_if.source   rsp
);
	import efbrp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer: one transaction at a time.
	efbrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Map, contents memory, scan counter and response register.
	efbrp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_func        (req.func),
		.req_block_index (req.block_index),
		.req_data_low    (req.data_low),
		.req_data_high   (req.data_high),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_status      (rsp.status),
		.rsp_slot        (rsp.slot),
		.rsp_tag         (rsp.tag)
	);

	// Port-side check of the response transaction.
	efbrp_rsp_check u_rsp_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.rsp_slot   (rsp.slot),
		.rsp_tag    (rsp.tag)
	);

endmodule

`default_nettype wire

### hw/rtl/efbrp_datapath.sv
// ----------------------------------------------------------------------------
// efbrp_datapath: map registers, block contents memory and scan unit
// Holds the request, scans the usage map and owns the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module efbrp_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire efbrp_pkg::cmd_t            cmd,
	output efbrp_pkg::sts_t                 sts,
	input  wire logic                       req_func,
	input  wire logic [4:0]                 req_block_index,
	input  wire logic [63:0]                req_data_low,
	input  wire logic [63:0]                req_data_high,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output logic [2:0]                      rsp_status,
	output logic [4:0]                      rsp_slot,
	output logic [7:0]                      rsp_tag
);
	import efbrp_pkg::*;

	logic                func_q;
	logic [IDX_W-1:0]    idx_q;
	logic [WORD_W-1:0]   lo_q;
	logic [WORD_W-1:0]   hi_q;
	logic [7:0]          tag_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [BLOCK_W-1:0]  rd_q;
	logic [7:0]          map_q [MAP_SLOTS];
	logic [BLOCK_W-1:0]  mem [MAP_SLOTS];
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_wa;
	logic [BLOCK_W-1:0]  blk;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [4:0]          out_slot_q;
	logic [7:0]          out_tag_q;
	logic                granted;

	assign blk = {hi_q, lo_q};

	// Hold the transaction.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= req_func;
			idx_q  <= req_block_index;
			lo_q   <= req_data_low;
			hi_q   <= req_data_high;
			tag_q  <= make_tag(req_block_index);
		end
		if (cmd.slot_take)
			slot_q <= cnt_q;
		if (cmd.rd)
			rd_q <= mem[slot_q];
	end

	// Scan counter: forward for the tag match, backward for the free slot.
	always_ff @(posedge clk) begin
		if (cmd.scan_fwd_init)
			cnt_q <= '0;
		else if (cmd.scan_rev_init)
			cnt_q <= SLOT_W'(MAP_SLOTS - 1);
		else if (cmd.scan_fwd_step)
			cnt_q <= cnt_q + SLOT_W'(1);
		else if (cmd.scan_rev_step)
			cnt_q <= cnt_q - SLOT_W'(1);
	end

	// Usage map, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MAP_SLOTS; m++)
				map_q[m] <= '0;
		end else if (cmd.load_wr) begin
			for (int m = 0; m < MAP_SLOTS; m++) begin
				if (m < 16 && idx_q == IDX_W'(PHYS_BLOCKS - 2))
					map_q[m] <= blk[(m % 16) * 8 +: 8];
				else if (m >= 16 && m < 32 && idx_q == IDX_W'(PHYS_BLOCKS - 1))
					map_q[m] <= blk[(m % 16) * 8 +: 8];
			end
		end else if (cmd.commit) begin
			map_q[slot_q] <= tag_q;
		end
	end

	// Block contents memory.
	assign mem_we = (cmd.load_wr && int'(idx_q) < MAP_SLOTS) || cmd.commit;
	assign mem_wa = cmd.commit ? slot_q : idx_q[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= blk;
	end

	// Response register.
	assign granted = (cmd.res_status == ST_REUSE) || (cmd.res_status == ST_NEW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.res_load)
			out_valid_q <= 1'b1;
		else if (rsp_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= cmd.res_status;
			out_slot_q   <= granted ? 5'(slot_q) : 5'd0;
			out_tag_q    <= granted ? tag_q : 8'd0;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_slot   = out_slot_q;
	assign rsp_tag    = out_tag_q;

	always_comb begin
		sts.plan     = (func_q == FN_PLAN);
		sts.idx_big  = int'(idx_q) >= LOGICAL_BLOCKS;
		sts.hit      = map_q[cnt_q] == tag_q;
		sts.free     = map_q[cnt_q] == 8'd0;
		sts.cnt_last = cnt_q == SLOT_W'(MAP_SLOTS - 1);
		sts.cnt_zero = cnt_q == '0;
		sts.all_ff   = (&lo_q) && (&hi_q);
		sts.rises    = ((rd_q[WORD_W-1:0] & ~lo_q) == '0) &&
			((rd_q[BLOCK_W-1:WORD_W] & ~hi_q) == '0);
		sts.out_busy = out_valid_q && !rsp_ready;
	end

	a_commit_tag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> map_q[slot_q] == tag_q)
		else $error("map entry does not hold the committed tag");

	a_take_on_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slot_take |-> (sts.hit || sts.free))
		else $error("slot taken without a match or a free entry");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_fwd_step || cmd.scan_rev_step) |=> int'(cnt_q) < MAP_SLOTS)
		else $error("scan counter left the map");

endmodule

`default_nettype wire

### hw/rtl/efbrp_ctrl.sv
// ----------------------------------------------------------------------------
// efbrp_ctrl: sequencer of the planner
// Steps one transaction through dispatch, map scans, checks and response.
// ----------------------------------------------------------------------------
`default_nettype none

module efbrp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire efbrp_pkg::sts_t  sts,
	output efbrp_pkg::cmd_t       cmd
);
	import efbrp_pkg::*;

	state_t  state_q, state_d;
	status_t result_q, result_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			result_q <= ST_LOADED;
		end else begin
			state_q  <= state_d;
			result_q <= result_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		result_d       = result_q;
		cmd            = '0;
		cmd.res_status = result_q;
		req_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid)
					state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (!sts.plan) begin
					cmd.load_wr = 1'b1;
					result_d    = ST_LOADED;
					state_d     = S_RESP;
				end else if (sts.idx_big) begin
					result_d = ST_INVALID;
					state_d  = S_RESP;
				end else begin
					cmd.scan_fwd_init = 1'b1;
					state_d           = S_SCAN_HIT;
				end
			end
			S_SCAN_HIT: begin
				if (sts.hit) begin
					cmd.slot_take = 1'b1;
					state_d       = S_RD_HIT;
				end else if (sts.cnt_last) begin
					if (sts.all_ff) begin
						result_d = ST_SKIP;
						state_d  = S_RESP;
					end else begin
						cmd.scan_rev_init = 1'b1;
						state_d           = S_SCAN_FREE;
					end
				end else begin
					cmd.scan_fwd_step = 1'b1;
				end
			end
			S_RD_HIT: begin
				cmd.rd  = 1'b1;
				state_d = S_CHK_HIT;
			end
			S_CHK_HIT: begin
				if (sts.rises) begin
					cmd.commit = 1'b1;
					result_d   = ST_REUSE;
					state_d    = S_RESP;
				end else begin
					cmd.scan_rev_init = 1'b1;
					state_d           = S_SCAN_FREE;
				end
			end
			S_SCAN_FREE: begin
				if (sts.free) begin
					cmd.slot_take = 1'b1;
					state_d       = S_RD_FREE;
				end else if (sts.cnt_zero) begin
					result_d = ST_FULL;
					state_d  = S_RESP;
				end else begin
					cmd.scan_rev_step = 1'b1;
				end
			end
			S_RD_FREE: begin
				cmd.rd  = 1'b1;
				state_d = S_CHK_FREE;
			end
			S_CHK_FREE: begin
				if (sts.rises) begin
					cmd.commit = 1'b1;
					result_d   = ST_NEW;
				end else begin
					result_d = ST_INVALID;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !sts.out_busy)
		else $error("response register overwritten while still pending");

	a_commit_then_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == S_RESP &&
			(result_q == ST_REUSE || result_q == ST_NEW))
		else $error("commit not followed by a granting response");

	a_capture_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_DISPATCH && !req_ready)
		else $error("accepted transaction not dispatched");

endmodule

`default_nettype wire

### hw/rtl/efbrp_ctrl_wrap_note.sv
// ----------------------------------------------------------------------------
// efbrp_rsp_check: port-side checker of the response channel
// Watches the response handshake of the planner from its ports alone.
// ----------------------------------------------------------------------------
`default_nettype none

module efbrp_rsp_check (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rsp_valid,
	input  wire logic       rsp_ready,
	input  wire logic [2:0] rsp_status,
	input  wire logic [4:0] rsp_slot,
	input  wire logic [7:0] rsp_tag
);
	import efbrp_pkg::*;

	logic granted;

	assign granted = (rsp_status == ST_REUSE) || (rsp_status == ST_NEW);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("stalled response changed");

	a_zero_when_none: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !granted |-> rsp_slot == 5'd0 && rsp_tag == 8'd0)
		else $error("slot or tag nonzero without a grant");

	a_tag_parity: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && granted |-> rsp_tag == make_tag(rsp_tag[4:0]) &&
			rsp_tag[5] == 1'b0)
		else $error("granted tag has bad parity bits");

endmodule

`default_nettype wire
